[design/onewire_rom_search_defines.svh]
// ----------------------------------------------------------------------------
// onewire_rom_search_defines.svh
// Assertion macros for the 1-Wire search-ROM engine. Empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_ROM_SEARCH_DEFINES_SVH
`define ONEWIRE_ROM_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define OWS_ASSERT_IMP(label, clock, reset_n, cond, prop) \
    label: assert property (@(posedge clock) disable iff (!(reset_n)) \
        (cond) |-> (prop)) else $error("onewire_rom_search: check failed");

// Next-cycle implication, checked out of reset.
`define OWS_ASSERT_NEXT(label, clock, reset_n, cond, prop) \
    label: assert property (@(posedge clock) disable iff (!(reset_n)) \
        (cond) |=> (prop)) else $error("onewire_rom_search: check failed");

`else

`define OWS_ASSERT_IMP(label, clock, reset_n, cond, prop)
`define OWS_ASSERT_NEXT(label, clock, reset_n, cond, prop)

`endif

`endif

[design/ows_pkg.sv]
// ----------------------------------------------------------------------------
// ows_pkg
// Types, codes and constants shared by the 1-Wire search-ROM engine.
// ----------------------------------------------------------------------------
package ows_pkg;

    // Number of ID bytes that a pass resolves (2 to 8).
    localparam int ID_BYTES = 8;
    localparam int ID_BITS  = ID_BYTES * 8;

    // Fixed field widths.
    localparam int ROM_W  = 64;
    localparam int POS_W  = 7;
    localparam int IDX_W  = 6;
    localparam int CRC_W  = 8;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    // Dallas CRC-8, reflected polynomial.
    localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;

    // Transaction kinds.
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAIR    = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_NONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SEARCH = 2'd1;
    localparam logic [STAT_W-1:0] ST_CONT   = 2'd2;
    localparam logic [STAT_W-1:0] ST_END    = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              device_present;
        logic              id_bit;
        logic              complement_bit;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              write_valid;
        logic              direction;
        logic              found;
        logic              last_device;
        logic [ROM_W-1:0]  rom_id;
    } res_t;

    typedef struct packed {
        logic [ROM_W-1:0] rom_bits;
        logic [POS_W-1:0] last_discrepancy;
        logic             last_device_flag;
        logic [POS_W-1:0] bit_position;
        logic [POS_W-1:0] last_zero_position;
        logic [CRC_W-1:0] running_crc;
        logic             in_pass;
    } search_state_t;

endpackage

[design/onewire_rom_search.sv]
// ----------------------------------------------------------------------------
// onewire_rom_search
// Decision engine of the 1-Wire search-ROM algorithm. Each command transaction
// (restart search, start pass with the bus-reset presence result, or a read
// bit/complement pair) yields exactly one result transaction that tells the
// bus controller what to do next: issue the search command, write the chosen
// direction bit, or close the pass with the found ID, its found flag and the
// last-device flag. The engine keeps the ID being built, the last discrepancy,
// the last zero position and a running Dallas CRC-8; any failed pass (1/1 pair,
// no presence, bad CRC, zero family byte) clears the discrepancy state so the
// next pass starts over. Throughput is one transaction per clock cycle while
// the result side does not stall: a command lands in an input register, the
// decision is made from it and the registered search state in combinational
// logic, and the result is captured in a result register. A result is thus
// offered once its command has passed the input and the result register.
// While a finished result waits to be taken, the input register can still
// accept one more command; the command channel then stalls until the
// waiting result moves on.
// ----------------------------------------------------------------------------
`include "onewire_rom_search_defines.svh"

module onewire_rom_search (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  ows_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output ows_pkg::res_t res
);

    // Input register: holds one command transaction until the decision
    // logic consumes it.
    logic                   cmd_valid_reg;
    logic                   cmd_valid_next;
    ows_pkg::cmd_t          cmd_reg;

    // Result register: one finished result awaiting the consumer.
    logic                   res_valid_reg;
    logic                   res_valid_next;
    ows_pkg::res_t          res_reg;

    // Search state, updated once per decided command.
    ows_pkg::search_state_t state_reg;
    ows_pkg::search_state_t state_next;

    // Decision outputs.
    ows_pkg::search_state_t dec_state;
    ows_pkg::res_t          dec_res;

    logic                   cmd_take;
    logic                   advance;

    // The held command is decided when the result register is empty or is
    // being emptied in this same cycle.
    assign advance   = cmd_valid_reg && (!res_valid_reg || !res_stall);
    // The input register takes a new command whenever it is empty or its
    // current command moves on this cycle.
    assign cmd_stall = cmd_valid_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    ows_decide u_decide (
        .st      (state_reg),
        .cmd     (cmd_reg),
        .st_next (dec_state),
        .res     (dec_res)
    );

    always_comb
    begin
        if (cmd_take)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (advance)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end

        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end

        state_next = advance ? dec_state : state_reg;
    end

    // Control and search state, reset (bit position to 1, the rest cleared).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg                <= 1'b0;
            res_valid_reg                <= 1'b0;
            state_reg.rom_bits           <= '0;
            state_reg.last_discrepancy   <= '0;
            state_reg.last_device_flag   <= 1'b0;
            state_reg.bit_position       <= ows_pkg::POS_W'(1);
            state_reg.last_zero_position <= '0;
            state_reg.running_crc        <= '0;
            state_reg.in_pass            <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            res_valid_reg <= res_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
        if (advance)
        begin
            res_reg <= dec_res;
        end
    end

    // A direction is only reported together with a bus write.
    `OWS_ASSERT_IMP(a_dir_needs_write, clk, rst_n, res_valid_reg,
        res_reg.write_valid || !res_reg.direction)

    // A found ID is only reported when the pass closes.
    `OWS_ASSERT_IMP(a_found_at_end, clk, rst_n, res_valid_reg && res_reg.found,
        res_reg.status == ows_pkg::ST_END)

    // A bit pair that arrives outside a pass produces an empty result.
    `OWS_ASSERT_NEXT(a_pair_outside_pass, clk, rst_n,
        advance && (cmd_reg.kind == ows_pkg::KIND_PAIR) && !state_reg.in_pass,
        res_valid_reg && (res_reg.status == ows_pkg::ST_NONE))

    // The bit position never leaves the range 1 to one past the last ID bit.
    `OWS_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1,
        (state_reg.bit_position >= ows_pkg::POS_W'(1)) &&
        (state_reg.bit_position <= ows_pkg::POS_W'(ows_pkg::ID_BITS + 1)))

endmodule

[design/ows_decide.sv]
// ----------------------------------------------------------------------------
// ows_decide
// Combinational decision step: next search state and result for one command.
// ----------------------------------------------------------------------------
module ows_decide (
    input  ows_pkg::search_state_t st,
    input  ows_pkg::cmd_t          cmd,
    output ows_pkg::search_state_t st_next,
    output ows_pkg::res_t          res
);

    logic [ows_pkg::IDX_W-1:0] idx;
    logic                      dir;
    logic                      pair_ok;
    logic [ows_pkg::ROM_W-1:0] rom_mod;
    logic [ows_pkg::CRC_W-1:0] crc_next;
    logic [ows_pkg::POS_W-1:0] lz_next;
    logic                      last_bit;
    logic                      success;

    // One bit of the Dallas CRC-8, fed LSB first.
    function automatic logic [ows_pkg::CRC_W-1:0] crc_step(
        input logic [ows_pkg::CRC_W-1:0] crc,
        input logic                      bit_in
    );
        logic [ows_pkg::CRC_W-1:0] sh;
        sh = crc >> 1;
        if (crc[0] ^ bit_in)
        begin
            sh = sh ^ ows_pkg::CRC_POLY;
        end
        return sh;
    endfunction

    // Direction choice and the values it produces.
    always_comb
    begin
        idx     = ows_pkg::IDX_W'(st.bit_position - ows_pkg::POS_W'(1));
        pair_ok = (cmd.id_bit != cmd.complement_bit);
        if (pair_ok)
        begin
            dir = cmd.id_bit;
        end
        else if (st.bit_position < st.last_discrepancy)
        begin
            dir = st.rom_bits[idx];
        end
        else
        begin
            dir = (st.bit_position == st.last_discrepancy);
        end
        rom_mod      = st.rom_bits;
        rom_mod[idx] = dir;
        crc_next     = crc_step(st.running_crc, dir);
        lz_next      = (!pair_ok && !dir) ? st.bit_position : st.last_zero_position;
        last_bit     = (st.bit_position >= ows_pkg::POS_W'(ows_pkg::ID_BITS));
        success      = (crc_next == '0) && (rom_mod[7:0] != 8'd0);
    end

    always_comb
    begin
        st_next         = st;
        res.status      = ows_pkg::ST_NONE;
        res.write_valid = 1'b0;
        res.direction   = 1'b0;
        res.found       = 1'b0;
        res.last_device = 1'b0;

        unique case (cmd.kind)
            ows_pkg::KIND_RESTART:
            begin
                st_next.last_discrepancy   = '0;
                st_next.last_device_flag   = 1'b0;
                st_next.bit_position       = ows_pkg::POS_W'(1);
                st_next.last_zero_position = '0;
                st_next.running_crc        = '0;
                st_next.in_pass            = 1'b0;
            end
            ows_pkg::KIND_START:
            begin
                st_next.bit_position       = ows_pkg::POS_W'(1);
                st_next.last_zero_position = '0;
                st_next.running_crc        = '0;
                if (st.last_device_flag || !cmd.device_present)
                begin
                    st_next.last_discrepancy = '0;
                    st_next.last_device_flag = 1'b0;
                    st_next.in_pass          = 1'b0;
                    res.status               = ows_pkg::ST_END;
                end
                else
                begin
                    st_next.in_pass = 1'b1;
                    res.status      = ows_pkg::ST_SEARCH;
                end
            end
            ows_pkg::KIND_PAIR:
            begin
                if (st.in_pass)
                begin
                    if (cmd.id_bit && cmd.complement_bit)
                    begin
                        // No device answered this bit: the pass is lost.
                        st_next.in_pass          = 1'b0;
                        st_next.last_discrepancy = '0;
                        st_next.last_device_flag = 1'b0;
                        res.status               = ows_pkg::ST_END;
                    end
                    else
                    begin
                        st_next.rom_bits           = rom_mod;
                        st_next.running_crc        = crc_next;
                        st_next.last_zero_position = lz_next;
                        st_next.bit_position       =
                            ows_pkg::POS_W'(st.bit_position + ows_pkg::POS_W'(1));
                        res.write_valid            = 1'b1;
                        res.direction              = dir;
                        if (last_bit)
                        begin
                            st_next.in_pass = 1'b0;
                            res.status      = ows_pkg::ST_END;
                            if (success)
                            begin
                                st_next.last_discrepancy = lz_next;
                                st_next.last_device_flag =
                                    st.last_device_flag || (lz_next == '0);
                                res.found       = 1'b1;
                                res.last_device =
                                    st.last_device_flag || (lz_next == '0);
                            end
                            else
                            begin
                                st_next.last_discrepancy = '0;
                                st_next.last_device_flag = 1'b0;
                            end
                        end
                        else
                        begin
                            res.status = ows_pkg::ST_CONT;
                        end
                    end
                end
            end
            default:
            begin
                // Unused kind: state holds, empty result.
            end
        endcase

        res.rom_id = st_next.rom_bits;
    end

endmodule
